// ===== rtl/modular_exponentiation_defines.svh =====
// Assertion macros shared by the modular exponentiation RTL.
// No dependencies; included inside module bodies.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Concurrent assertion: the property is checked at every rising clock edge out of reset.
`define MODEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/modexp_pkg.sv =====
// Shared types for the modular exponentiation block.
// No dependencies.
package modexp_pkg;

  // Status reported by the multiply-reduce unit to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } modexp_mm_stat_t;

endpackage

// ===== rtl/modexp_mulmod.sv =====
// Iterative interleaved multiply-reduce unit: r = (p * q) mod m, one multiplier bit per cycle.
// Depends on modexp_pkg and modular_exponentiation_defines.svh.
module modexp_mulmod #(
  parameter int W = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [W-1:0]                p_i,
  input  logic [W-1:0]                q_i,
  input  logic [W-1:0]                m_i,
  output modexp_pkg::modexp_mm_stat_t stat_o,
  output logic [W-1:0]                res_o
);
  import modexp_pkg::*;
  `include "modular_exponentiation_defines.svh"

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  r_q, r_d;
  logic [W-1:0]  qsh_q, qsh_d;
  logic [W-1:0]  p_q, p_d;
  logic [W-1:0]  m_q, m_d;

  logic [W+1:0]  t, t_m1, t_m2, m1, m2;

  // p <= m and r < m keep 2r + p below 3m: at most two subtractions, tried in parallel.
  always_comb begin
    m1   = {2'b00, m_q};
    m2   = {1'b0, m_q, 1'b0};
    t    = {1'b0, r_q, 1'b0} + (qsh_q[W-1] ? {2'b00, p_q} : '0);
    t_m1 = t - m1;
    t_m2 = t - m2;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    qsh_d  = qsh_q;
    p_d    = p_q;
    m_d    = m_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      qsh_d  = q_i;
      p_d    = p_i;
      m_d    = m_i;
    end else if (busy_q) begin
      priority if (t >= m2) begin
        r_d = t_m2[W-1:0];
      end else if (t >= m1) begin
        r_d = t_m1[W-1:0];
      end else begin
        r_d = t[W-1:0];
      end
      qsh_d = qsh_q << 1;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    qsh_q <= qsh_d;
    p_q   <= p_d;
    m_q   <= m_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = r_q;

  `MODEXP_ASSERT(a_go_when_free, clk_i, rst_ni, go_i |-> !busy_q, "mulmod started while busy")
  `MODEXP_ASSERT(a_done_not_busy, clk_i, rst_ni, done_q |-> !busy_q, "done raised while busy")
  `MODEXP_ASSERT(a_res_reduced, clk_i, rst_ni, done_q |-> (r_q < m_q), "result not reduced")
  `MODEXP_ASSERT_NEXT(a_go_busy, clk_i, rst_ni, go_i, busy_q, "mulmod did not start")

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: sequencer around one multiply-reduce unit.
// Depends on modexp_pkg, modexp_mulmod and modular_exponentiation_defines.svh.
//
// Computes power_mod = base ^ exponent mod modulus by right-to-left square-and-multiply.
// A transaction is taken when start is high and busy is low; busy then stays high until
// the result has been produced. The result appears on power_mod_o for exactly one cycle,
// marked by result_valid_o, and the receiver cannot stall it, so it must be captured then.
// A new start is accepted in that same cycle. All arithmetic goes through one shared
// multiply-reduce unit that retires one multiplier bit per cycle. Besides the initial
// reduction of base, a transaction runs one squaring per exponent bit below the highest
// set bit and one multiply per set exponent bit, all through that unit, which finishes
// one product before it takes the next. A zero exponent finishes after the base
// reduction; a zero modulus (out of range) returns 0 without raising busy.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPERAND_WIDTH-1:0] base_i,
  input  logic [OPERAND_WIDTH-1:0] exponent_i,
  input  logic [OPERAND_WIDTH-1:0] modulus_i,
  output logic                     result_valid_o,
  output logic [OPERAND_WIDTH-1:0] power_mod_o
);
  import modexp_pkg::*;
  `include "modular_exponentiation_defines.svh"

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for start
    S_RED  = 4'b0010,  // base mod modulus
    S_MUL  = 4'b0100,  // acc * sq
    S_SQR  = 4'b1000   // sq * sq
  } modexp_state_e;

  modexp_state_e   state_q, state_d;
  logic            go_q, go_d;
  logic            valid_q, valid_d;
  logic [W-1:0]    pm_q, pm_d;
  logic [W-1:0]    e_q, e_d;
  logic [W-1:0]    mod_q, mod_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    sq_q, sq_d;
  logic [W-1:0]    op_p_q, op_p_d;
  logic [W-1:0]    op_q_q, op_q_d;

  modexp_mm_stat_t mm_stat;
  logic [W-1:0]    mm_res;
  logic [W-1:0]    acc_init;
  logic [W-1:0]    e_shr;

  modexp_mulmod #(
    .W(W)
  ) u_mulmod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (go_q),
    .p_i   (op_p_q),
    .q_i   (op_q_q),
    .m_i   (mod_q),
    .stat_o(mm_stat),
    .res_o (mm_res)
  );

  // 1 mod m: zero only for a modulus of one
  assign acc_init = {{(W-1){1'b0}}, (mod_q != W'(1))};
  assign e_shr    = e_q >> 1;

  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    valid_d = 1'b0;
    pm_d    = pm_q;
    e_d     = e_q;
    mod_d   = mod_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    op_p_d  = op_p_q;
    op_q_d  = op_q_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          e_d   = exponent_i;
          mod_d = modulus_i;
          if (modulus_i == '0) begin
            // no reduction possible: answer 0 at once
            pm_d    = '0;
            valid_d = 1'b1;
          end else begin
            // base * 1 through the unit reduces base below modulus
            op_p_d  = W'(1);
            op_q_d  = base_i;
            go_d    = 1'b1;
            state_d = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_stat.done) begin
          sq_d  = mm_res;
          acc_d = acc_init;
          priority if (e_q == '0) begin
            pm_d    = acc_init;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else if (e_q[0]) begin
            op_p_d  = acc_init;
            op_q_d  = mm_res;
            go_d    = 1'b1;
            state_d = S_MUL;
          end else begin
            op_p_d  = mm_res;
            op_q_d  = mm_res;
            go_d    = 1'b1;
            state_d = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          acc_d = mm_res;
          if (e_shr == '0) begin
            // top exponent bit done: the last square is never needed
            pm_d    = mm_res;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            op_p_d  = sq_q;
            op_q_d  = sq_q;
            go_d    = 1'b1;
            state_d = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_stat.done) begin
          sq_d = mm_res;
          e_d  = e_shr;
          priority if (e_shr == '0) begin
            pm_d    = acc_q;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else if (e_shr[0]) begin
            op_p_d  = acc_q;
            op_q_d  = mm_res;
            go_d    = 1'b1;
            state_d = S_MUL;
          end else begin
            op_p_d  = mm_res;
            op_q_d  = mm_res;
            go_d    = 1'b1;
            state_d = S_SQR;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pm_q   <= pm_d;
    e_q    <= e_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    op_p_q <= op_p_d;
    op_q_q <= op_q_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign power_mod_o    = pm_q;

  `MODEXP_ASSERT(a_res_in_range, clk_i, rst_ni,
    valid_q |-> ((pm_q < mod_q) || (pm_q == '0)), "result not below modulus")
  `MODEXP_ASSERT(a_done_in_work, clk_i, rst_ni,
    mm_stat.done |-> (state_q != S_IDLE), "unit finished while sequencer idle")
  `MODEXP_ASSERT(a_go_in_work, clk_i, rst_ni,
    go_q |-> (state_q != S_IDLE), "unit launched while sequencer idle")
  `MODEXP_ASSERT(a_go_unit_free, clk_i, rst_ni,
    go_q |-> !mm_stat.busy, "unit launched while still working")
  `MODEXP_ASSERT_NEXT(a_start_taken, clk_i, rst_ni,
    start && !busy, busy || result_valid_o, "accepted transaction dropped")

endmodule
